### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the RTL. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/srmsn_pkg.sv
// ----------------------------------------------------------------------------
// srmsn_pkg
// Types and constants shared by the scaled RMS error norm block.
// ----------------------------------------------------------------------------
package srmsn_pkg;

    localparam int DATA_W            = 32;
    localparam int ACC_W             = 64;
    localparam int MAX_EQUATIONS_DEF = 256;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ABS_TOL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REL_TOL = 1'b1;

    localparam logic [DATA_W-1:0] ABS_TOL_RESET = 32'd429;
    localparam logic [DATA_W-1:0] REL_TOL_RESET = 32'd4295;

    // Shift-subtract unit step counts.
    localparam int STEP_CNT_W  = 6;
    localparam int RATIO_STEPS = 32;
    localparam int MEAN_STEPS  = 64;
    localparam int SQRT_STEPS  = 32;

    typedef enum logic [1:0] {
        OP_RATIO,
        OP_MEAN,
        OP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] old_value;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] error_estimate;
        logic                     is_last;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] error_norm;
        logic              saturated;
    } result_t;

    typedef struct packed {
        logic             load;
        unit_op_t         op;
        logic [ACC_W-1:0] rem_init;
        logic [ACC_W-1:0] acc_init;
        logic [ACC_W-1:0] divisor;
    } unit_cmd_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } unit_status_t;

endpackage

### sv/srmsn_mul.sv
// ----------------------------------------------------------------------------
// srmsn_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module srmsn_mul
(
    input  logic                                 clk,
    input  logic [srmsn_pkg::DATA_W-1:0]         a,
    input  logic [srmsn_pkg::DATA_W-1:0]         b,
    output logic [srmsn_pkg::ACC_W-1:0]          product
);

    logic [srmsn_pkg::ACC_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= srmsn_pkg::ACC_W'(a) * srmsn_pkg::ACC_W'(b);
    end

    assign product = product_reg;

endmodule

### sv/srmsn_shift_sub.sv
// ----------------------------------------------------------------------------
// srmsn_shift_sub
// Iterative shift-subtract unit: restoring division one quotient bit per
// cycle, or integer square root one root bit per cycle.
// ----------------------------------------------------------------------------
module srmsn_shift_sub
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  srmsn_pkg::unit_cmd_t     cmd,
    output srmsn_pkg::unit_status_t  status
);

    logic [srmsn_pkg::ACC_W-1:0]      rem_reg;
    logic [srmsn_pkg::ACC_W-1:0]      acc_reg;
    logic [srmsn_pkg::ACC_W-1:0]      q_reg;
    logic [srmsn_pkg::ACC_W-1:0]      div_reg;
    srmsn_pkg::unit_op_t              op_reg;
    logic [srmsn_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [srmsn_pkg::ACC_W:0]        partial;
    logic [srmsn_pkg::ACC_W:0]        trial;
    logic [srmsn_pkg::ACC_W:0]        diff;
    logic [srmsn_pkg::ACC_W-1:0]      acc_shift;
    logic                             ge;
    logic [srmsn_pkg::STEP_CNT_W-1:0] load_cnt;

    // The square root brings down two bits per step and tries 4 * root + 1.
    always_comb
    begin
        case (op_reg)
            srmsn_pkg::OP_SQRT:
            begin
                partial   = {rem_reg[srmsn_pkg::ACC_W-2:0], acc_reg[srmsn_pkg::ACC_W-1 -: 2]};
                trial     = {q_reg[srmsn_pkg::ACC_W-2:0], 2'b01};
                acc_shift = {acc_reg[srmsn_pkg::ACC_W-3:0], 2'b00};
            end
            default:
            begin
                partial   = {rem_reg, acc_reg[srmsn_pkg::ACC_W-1]};
                trial     = {1'b0, div_reg};
                acc_shift = {acc_reg[srmsn_pkg::ACC_W-2:0], 1'b0};
            end
        endcase
        ge   = (partial >= trial);
        diff = partial - trial;
    end

    always_comb
    begin
        case (cmd.op)
            srmsn_pkg::OP_RATIO: load_cnt = srmsn_pkg::STEP_CNT_W'(srmsn_pkg::RATIO_STEPS - 1);
            srmsn_pkg::OP_MEAN:  load_cnt = srmsn_pkg::STEP_CNT_W'(srmsn_pkg::MEAN_STEPS - 1);
            srmsn_pkg::OP_SQRT:  load_cnt = srmsn_pkg::STEP_CNT_W'(srmsn_pkg::SQRT_STEPS - 1);
            default:             load_cnt = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= srmsn_pkg::OP_RATIO;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= load_cnt;
                op_reg   <= cmd.op;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= cmd.rem_init;
            acc_reg <= cmd.acc_init;
            div_reg <= cmd.divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[srmsn_pkg::ACC_W-1:0] : partial[srmsn_pkg::ACC_W-1:0];
            acc_reg <= acc_shift;
            q_reg   <= {q_reg[srmsn_pkg::ACC_W-2:0], ge};
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = q_reg;

endmodule

### sv/scaled_rms_error_norm_core.sv
// ----------------------------------------------------------------------------
// scaled_rms_error_norm_core
// RMS norm of tolerance-scaled errors over a vector of equations.
// A request is taken when start is high and busy is low. Each request holds one
// equation's old value, new value and error estimate; the one marked is_last
// closes the vector. Only that request yields a result, shown for exactly one
// cycle with result_valid high; the receiver cannot stall it. A plain request
// keeps busy high for multiply, scale check, 32-step divide, square and add;
// one whose ratio saturates skips the divide. A request that arrives with the
// vector already at capacity and is not last leaves busy low. A last request
// adds a mean load, a 64-step mean division and a 32-step square root, and
// result_valid rises in the same cycle that busy falls. All of it runs on one
// shift-subtract unit and one multiplier. Tolerances are written on the cfg
// channel, which is always ready; write them only while busy is low. Reset
// restores the default tolerances and clears the running sum, count and
// saturation flag; no clearing pass follows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_rms_error_norm_core
#(
    parameter int MAX_EQUATIONS = srmsn_pkg::MAX_EQUATIONS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  srmsn_pkg::item_t                  item,
    output logic                              result_valid,
    output srmsn_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srmsn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srmsn_pkg::DATA_W-1:0]      cfg_data
);

    localparam int COUNT_W = $clog2(MAX_EQUATIONS + 1);
    localparam int DW      = srmsn_pkg::DATA_W;
    localparam int AW      = srmsn_pkg::ACC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_MUL,
        ST_SCALE,
        ST_DIV,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_LOAD,
        ST_MEAN,
        ST_SQRT
    } state_t;

    state_t                  state_reg;
    logic [DW-1:0]           abs_tol_reg;
    logic [DW-1:0]           rel_tol_reg;
    logic [AW-1:0]           sum_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    sat_seen_reg;
    logic [DW-1:0]           m_max_reg;
    logic [DW-1:0]           m_err_reg;
    logic                    last_reg;
    logic [DW-1:0]           ratio_reg;
    logic                    result_valid_reg;
    srmsn_pkg::result_t      result_reg;

    logic [DW-1:0]           m_old;
    logic [DW-1:0]           m_new;
    logic [DW-1:0]           m_err;
    logic                    accept;
    logic                    full;
    logic [DW-1:0]           mul_a;
    logic [DW-1:0]           mul_b;
    logic [AW-1:0]           product;
    logic [AW-1:0]           scale;
    logic [AW-1:0]           err_shifted;
    logic                    ratio_sat;
    logic [AW:0]             sum_ext;
    logic [AW-1:0]           divisor_n;
    srmsn_pkg::unit_cmd_t    unit_cmd;
    srmsn_pkg::unit_status_t unit_status;

    // Two's complement magnitude; the most negative value maps to 2^31 exactly.
    assign m_old = item.old_value[DW-1] ? (~item.old_value + 1'b1) : item.old_value;
    assign m_new = item.new_value[DW-1] ? (~item.new_value + 1'b1) : item.new_value;
    assign m_err = item.error_estimate[DW-1] ?
                   (~item.error_estimate + 1'b1) : item.error_estimate;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign full   = (count_reg >= COUNT_W'(MAX_EQUATIONS));

    assign mul_a = (state_reg == ST_SQUARE) ? ratio_reg : rel_tol_reg;
    assign mul_b = (state_reg == ST_SQUARE) ? ratio_reg : m_max_reg;

    // Scale is Q32.32; the error is lifted to the same point before dividing.
    assign scale       = {16'h0, abs_tol_reg, 16'h0} + product;
    assign err_shifted = {16'h0, m_err_reg, 16'h0};
    assign ratio_sat   = (scale == '0) || (err_shifted >= scale);
    assign sum_ext     = {1'b0, sum_reg} + {1'b0, product};
    assign divisor_n   = (count_reg == '0) ? AW'(1) : AW'(count_reg);

    srmsn_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    always_comb
    begin
        unit_cmd = '0;
        case (state_reg)
            ST_SCALE:
            begin
                unit_cmd.load     = !ratio_sat;
                unit_cmd.op       = srmsn_pkg::OP_RATIO;
                unit_cmd.rem_init = err_shifted;
                unit_cmd.acc_init = '0;
                unit_cmd.divisor  = scale;
            end
            ST_MEAN_LOAD:
            begin
                unit_cmd.load     = 1'b1;
                unit_cmd.op       = srmsn_pkg::OP_MEAN;
                unit_cmd.rem_init = '0;
                unit_cmd.acc_init = sum_reg;
                unit_cmd.divisor  = divisor_n;
            end
            ST_MEAN:
            begin
                unit_cmd.load     = unit_status.done;
                unit_cmd.op       = srmsn_pkg::OP_SQRT;
                unit_cmd.rem_init = '0;
                unit_cmd.acc_init = unit_status.quotient;
                unit_cmd.divisor  = '0;
            end
            default:
            begin
                unit_cmd = '0;
            end
        endcase
    end

    srmsn_shift_sub u_shift_sub
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (unit_cmd),
        .status (unit_status)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= srmsn_pkg::ABS_TOL_RESET;
            rel_tol_reg <= srmsn_pkg::REL_TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srmsn_pkg::REG_ABS_TOL: abs_tol_reg <= cfg_data;
                srmsn_pkg::REG_REL_TOL: rel_tol_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            sat_seen_reg     <= 1'b0;
            m_max_reg        <= '0;
            m_err_reg        <= '0;
            last_reg         <= 1'b0;
            ratio_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        m_max_reg <= (m_old > m_new) ? m_old : m_new;
                        m_err_reg <= m_err;
                        last_reg  <= item.is_last;
                        if (full)
                        begin
                            // Beyond capacity the equation is dropped but flagged.
                            sat_seen_reg <= 1'b1;
                            if (item.is_last)
                            begin
                                state_reg <= ST_MEAN_LOAD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_SCALE_MUL;
                        end
                    end
                end
                ST_SCALE_MUL:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    if (ratio_sat)
                    begin
                        ratio_reg    <= '1;
                        sat_seen_reg <= 1'b1;
                        state_reg    <= ST_SQUARE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (unit_status.done)
                    begin
                        ratio_reg <= unit_status.quotient[DW-1:0];
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    if (sum_ext[AW])
                    begin
                        sum_reg      <= '1;
                        sat_seen_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_ext[AW-1:0];
                    end
                    count_reg <= count_reg + 1'b1;
                    state_reg <= last_reg ? ST_MEAN_LOAD : ST_IDLE;
                end
                ST_MEAN_LOAD:
                begin
                    state_reg <= ST_MEAN;
                end
                ST_MEAN:
                begin
                    if (unit_status.done)
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (unit_status.done)
                    begin
                        result_reg.error_norm <= unit_status.quotient[DW-1:0];
                        result_reg.saturated  <= sat_seen_reg;
                        result_valid_reg      <= 1'b1;
                        sum_reg               <= '0;
                        count_reg             <= '0;
                        sat_seen_reg          <= 1'b0;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMP(a_result_idle, result_valid, !busy, "result shown while busy")
    `ASSERT_NEXT(a_result_strobe, result_valid, !result_valid, "result held past one cycle")
    `ASSERT_NEXT(a_last_goes_busy, start && !busy && item.is_last, busy, "last request lost")
    `ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(MAX_EQUATIONS), "item count beyond capacity")

endmodule
